// ===== hw/rtl/ktft_pkg.sv =====
// ----------------------------------------------------------------------------
// ktft_pkg
// Shared types and constants for the keyed triple-field table.
// ----------------------------------------------------------------------------
package ktft_pkg;

  localparam logic [2:0] REQ_HAS    = 3'd0;
  localparam logic [2:0] REQ_ADD    = 3'd1;
  localparam logic [2:0] REQ_DELETE = 3'd2;
  localparam logic [2:0] REQ_ASSIGN = 3'd3;
  localparam logic [2:0] REQ_MODIFY = 3'd4;
  localparam logic [2:0] REQ_GET    = 3'd5;
  localparam logic [2:0] REQ_CLEAR  = 3'd6;

  localparam logic [15:0] MISS_FIELD = 16'hFFD6;  // -42

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;  // latch incoming word
    logic search;   // register key match and free slot
    logic read;     // register field read at matched slot
    logic exec;     // update table and load result word
  } dp_cmd_t;

endpackage

// ===== hw/rtl/ktft_ctrl.sv =====
// ----------------------------------------------------------------------------
// ktft_ctrl
// Request sequencer and result word handshake for the keyed triple-field table.
// ----------------------------------------------------------------------------
module ktft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ktft_pkg::dp_cmd_t cmd
);
  import ktft_pkg::*;

  state_t state;
  state_t state_next;
  logic   exec_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    exec_fire   = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!out_valid || out_ready) begin
          exec_fire  = 1'b1;
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/ktft_datapath.sv =====
// ----------------------------------------------------------------------------
// ktft_datapath
// Key match array, slot valid bits, field memory and result word register.
// ----------------------------------------------------------------------------
module ktft_datapath #(
  parameter int          ENTRIES   = 16,
  parameter logic [15:0] SKIP_BITS = 16'h8000
) (
  input  logic               clk,
  input  logic               rst,
  input  ktft_pkg::dp_cmd_t  cmd,
  input  logic [2:0]         req_type,
  input  logic [7:0]         ability_type,
  input  logic signed [15:0] value_a,
  input  logic signed [15:0] value_b,
  input  logic signed [15:0] value_c,
  output logic               hit,
  output logic [7:0]         out_type,
  output logic signed [15:0] out_a,
  output logic signed [15:0] out_b,
  output logic signed [15:0] out_c,
  output logic               status
);
  import ktft_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  logic [2:0]   req_q;
  logic [7:0]   key_q;
  logic [15:0]  va_q;
  logic [15:0]  vb_q;
  logic [15:0]  vc_q;

  logic [ENTRIES-1:0] used;
  logic [7:0]         keys [ENTRIES];
  logic [15:0]        mem_a [ENTRIES];
  logic [15:0]        mem_b [ENTRIES];
  logic [15:0]        mem_c [ENTRIES];

  logic          found_c;
  logic [IW-1:0] idx_c;
  logic          free_c;
  logic [IW-1:0] free_idx_c;

  logic          found;
  logic [IW-1:0] idx;
  logic          free_ok;
  logic [IW-1:0] free_idx;

  logic [15:0] rd_a;
  logic [15:0] rd_b;
  logic [15:0] rd_c;

  logic          skip_a;
  logic          skip_b;
  logic          skip_c;
  logic          fields_match;
  logic          do_write;
  logic          do_append;
  logic          do_delete;
  logic          do_clear;
  logic          is_modify;
  logic [IW-1:0] wr_idx;
  logic [15:0]   wr_a;
  logic [15:0]   wr_b;
  logic [15:0]   wr_c;
  logic          hit_next;
  logic [7:0]    type_next;
  logic [15:0]   a_next;
  logic [15:0]   b_next;
  logic [15:0]   c_next;
  logic          status_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type;
      key_q <= ability_type;
      va_q  <= value_a;
      vb_q  <= value_b;
      vc_q  <= value_c;
    end
  end

  // parallel key compare, lowest index wins
  always_comb begin
    found_c    = 1'b0;
    idx_c      = '0;
    free_c     = 1'b0;
    free_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (used[i] && keys[i] == key_q) begin
        found_c = 1'b1;
        idx_c   = IW'(i);
      end
      if (!used[i]) begin
        free_c     = 1'b1;
        free_idx_c = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      found    <= found_c;
      idx      <= idx_c;
      free_ok  <= free_c;
      free_idx <= free_idx_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_a <= mem_a[idx];
      rd_b <= mem_b[idx];
      rd_c <= mem_c[idx];
    end
  end

  always_comb begin
    skip_a       = (va_q == SKIP_BITS);
    skip_b       = (vb_q == SKIP_BITS);
    skip_c       = (vc_q == SKIP_BITS);
    fields_match = (skip_a || va_q == rd_a) && (skip_b || vb_q == rd_b) &&
                   (skip_c || vc_q == rd_c);
    is_modify    = (req_q == REQ_MODIFY);
    do_write     = 1'b0;
    do_append    = 1'b0;
    do_delete    = 1'b0;
    do_clear     = 1'b0;
    hit_next     = 1'b0;
    type_next    = '0;
    a_next       = '0;
    b_next       = '0;
    c_next       = '0;
    status_next  = 1'b0;
    case (req_q)
      REQ_HAS: begin
        hit_next = found && fields_match;
      end
      REQ_ADD: begin
        if (found) begin
          do_write = 1'b1;
        end else if (free_ok) begin
          do_append = 1'b1;
        end else begin
          status_next = 1'b1;
        end
      end
      REQ_DELETE: begin
        do_delete = found;
      end
      REQ_ASSIGN, REQ_MODIFY: begin
        do_write = found;
      end
      REQ_GET: begin
        hit_next = found;
        if (found) begin
          type_next = key_q;
          a_next    = rd_a;
          b_next    = rd_b;
          c_next    = rd_c;
        end else begin
          a_next = MISS_FIELD;
          b_next = MISS_FIELD;
          c_next = MISS_FIELD;
        end
      end
      REQ_CLEAR: begin
        do_clear = 1'b1;
      end
      default: begin
      end
    endcase

    wr_idx = do_append ? free_idx : idx;
    if (do_append) begin
      wr_a = va_q;
      wr_b = vb_q;
      wr_c = vc_q;
    end else begin
      wr_a = skip_a ? rd_a : (is_modify ? rd_a + va_q : va_q);
      wr_b = skip_b ? rd_b : (is_modify ? rd_b + vb_q : vb_q);
      wr_c = skip_c ? rd_c : (is_modify ? rd_c + vc_q : vc_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (do_write || do_append)) begin
      mem_a[wr_idx] <= wr_a;
      mem_b[wr_idx] <= wr_b;
      mem_c[wr_idx] <= wr_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_append) begin
      keys[free_idx] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.exec) begin
      if (do_clear) begin
        used <= '0;
      end else if (do_delete) begin
        used[idx] <= 1'b0;
      end else if (do_append) begin
        used[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      hit      <= hit_next;
      out_type <= type_next;
      out_a    <= a_next;
      out_b    <= b_next;
      out_c    <= c_next;
      status   <= status_next;
    end
  end

endmodule

// ===== hw/rtl/keyed_triple_field_table_core.sv =====
// ----------------------------------------------------------------------------
// keyed_triple_field_table_core
// Small keyed table of three signed 16-bit fields with has/add/delete/assign/
// modify/get/clear requests and wildcard field operands.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on in_valid/in_ready, one result word per request
//   leaves on out_valid/out_ready.
//   A request passes these steps after acceptance: the accepting edge latches
//   the word, then the parallel key match over all slots is registered, then
//   the field memory read at the matched slot, and last the table is updated
//   and the result register loaded, which raises out_valid. in_ready is high
//   only while no request is in flight, so words are taken one at a time.
//   The result register frees the input side: the next request is accepted
//   while a result still waits. If the receiver stalls, the following request
//   holds in its last step until the waiting result is taken.
//   Reset (synchronous, active high) empties the table; key and field storage
//   is not cleared and is only used from occupied slots.
// ----------------------------------------------------------------------------
module keyed_triple_field_table_core #(
  parameter int ENTRIES   = 16,
  parameter int SKIP_CODE = -32768
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic [7:0]         ability_type,
  input  logic signed [15:0] value_a,
  input  logic signed [15:0] value_b,
  input  logic signed [15:0] value_c,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [7:0]         out_type,
  output logic signed [15:0] out_a,
  output logic signed [15:0] out_b,
  output logic signed [15:0] out_c,
  output logic               status
);
  import ktft_pkg::*;

  localparam logic [15:0] SKIP_BITS = 16'(SKIP_CODE);

  dp_cmd_t cmd;

  ktft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ktft_datapath #(
    .ENTRIES   (ENTRIES),
    .SKIP_BITS (SKIP_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_type     (req_type),
    .ability_type (ability_type),
    .value_a      (value_a),
    .value_b      (value_b),
    .value_c      (value_c),
    .hit          (hit),
    .out_type     (out_type),
    .out_a        (out_a),
    .out_b        (out_b),
    .out_c        (out_c),
    .status       (status)
  );

endmodule

// ===== hw/rtl/ktft_checker.sv =====
// ----------------------------------------------------------------------------
// ktft_checker
// Port-level checks for the keyed triple-field table, bound to the top level.
// ----------------------------------------------------------------------------
module ktft_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               hit,
  input logic [7:0]         out_type,
  input logic signed [15:0] out_a,
  input logic signed [15:0] out_b,
  input logic signed [15:0] out_c,
  input logic               status
);

  // hit, out_a and status hold while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(out_a) &&
      $stable(status))
    else $error("result word changed while stalled");

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("request accepted while another is in flight");

  // a dropped add carries no other result
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !hit && out_type == 8'd0 && out_a == 16'sd0 &&
      out_b == 16'sd0 && out_c == 16'sd0)
    else $error("dropped add with nonzero result fields");

  // no result without a prior request
  a_result_needs_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a request in flight");

endmodule

bind keyed_triple_field_table_core ktft_checker u_ktft_checker (.*);
